@@ src/port_probe_reply_classifier_core_defines.svh @@
// assertion macros for the port probe reply classifier checker
// needs a clk and rst signal in the scope that uses them
`ifndef PORT_PROBE_REPLY_CLASSIFIER_CORE_DEFINES_SVH
`define PORT_PROBE_REPLY_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PPR_ASSERT_SAME(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("ppr check failed");

// next-cycle implication, off during reset
`define PPR_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("ppr check failed");

`endif

@@ src/ppr_pkg.sv @@
// types, codes and helpers for the port probe reply classifier
// no dependencies
package ppr_pkg;

  typedef enum logic [2:0] {
    OP_TCP     = 3'd0,
    OP_ICMP    = 3'd1,
    OP_UDP     = 3'd2,
    OP_TIMEOUT = 3'd3,
    OP_START   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_SYN  = 3'd0,
    MODE_NULL = 3'd1,
    MODE_FIN  = 3'd2,
    MODE_XMAS = 3'd3,
    MODE_ACK  = 3'd4,
    MODE_UDP  = 3'd5
  } scan_mode_t;

  typedef enum logic [2:0] {
    V_NONE     = 3'd0,
    V_OPEN     = 3'd1,
    V_CLOSED   = 3'd2,
    V_FILTERED = 3'd3,
    V_UNFILT   = 3'd4,
    V_OPENFILT = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    REG_SCAN_MODE   = 3'd0,
    REG_TARGET_ADDR = 3'd1,
    REG_TARGET_PORT = 3'd2,
    REG_LOCAL_PORT  = 3'd3,
    REG_RETRY_LIMIT = 3'd4
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [15:0] LOCAL_PORT_RESET  = 16'd1025;
  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd3;

  localparam logic [7:0] ICMP_UNREACH   = 8'd3;
  localparam logic [7:0] CODE_HOST      = 8'd1;
  localparam logic [7:0] CODE_PROTO     = 8'd2;
  localparam logic [7:0] CODE_PORT      = 8'd3;
  localparam logic [7:0] CODE_NET_PROHI = 8'd9;
  localparam logic [7:0] CODE_HOST_PROH = 8'd10;
  localparam logic [7:0] CODE_ADMIN     = 8'd13;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        syn_bit;
    logic        ack_bit;
    logic        rst_bit;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] inner_src_port;
    logic [15:0] inner_dst_port;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       resend;
  } out_beat_t;

  function automatic logic filter_code(input logic [7:0] code, input logic with_port);
    logic hit;
    hit = (code inside {CODE_HOST, CODE_PROTO, CODE_NET_PROHI, CODE_HOST_PROH, CODE_ADMIN});
    return hit || (with_port && code == CODE_PORT);
  endfunction

endpackage

@@ src/ppr_if.sv @@
// valid/ready channels for input and result beats
// depends on ppr_pkg
interface ppr_in_if;
  logic               valid;
  logic               ready;
  ppr_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppr_out_if;
  logic               valid;
  logic               ready;
  ppr_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/port_probe_reply_classifier_core.sv @@
// Port probe reply classifier. Takes one beat per cycle when the result side
// keeps up; a beat passes an input register, is judged by combinational
// compare logic against the config registers and the retry/decided state,
// and any result then moves from the input register into the output register.
// Beats that give no result (starts, unmatched replies, anything after a
// verdict) leave nothing on the output. A stalled output register holds the
// input register, so at most two beats are in flight.
// Depends on ppr_pkg and ppr_if.
module port_probe_reply_classifier_core (
  input  logic                            clk,
  input  logic                            rst,
  ppr_in_if.sink                          in_ch,
  ppr_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [ppr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ppr_pkg::*;

  logic [2:0]  scan_mode;
  logic [31:0] target_addr;
  logic [15:0] target_port;
  logic [15:0] local_port;
  logic [3:0]  retry_limit;

  logic [3:0]  retries_left;
  logic [3:0]  retries_left_next;
  logic        decided;
  logic        decided_next;

  logic        s1_valid;
  in_beat_t    s1_beat;
  logic        out_valid;
  out_beat_t   out_beat;

  logic        adv;
  logic        res_valid;
  logic [2:0]  verdict;
  logic        resend;
  logic        from_host;
  logic        fwd_ports;
  logic        quoted;
  logic        tcp_mode;

  assign adv          = !out_valid || out_ch.ready;
  assign in_ch.ready  = !s1_valid || adv;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_SYN;
      target_addr <= '0;
      target_port <= '0;
      local_port  <= LOCAL_PORT_RESET;
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SCAN_MODE:   scan_mode   <= cfg_data[2:0];
        REG_TARGET_ADDR: target_addr <= cfg_data[31:0];
        REG_TARGET_PORT: target_port <= cfg_data[15:0];
        REG_LOCAL_PORT:  local_port  <= cfg_data[15:0];
        REG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_beat <= in_ch.data;
    end
  end

  // classification
  always_comb begin
    from_host = (s1_beat.src_addr == target_addr);
    fwd_ports = (s1_beat.src_port == target_port) && (s1_beat.dst_port == local_port);
    quoted    = (s1_beat.inner_src_port == local_port) &&
                (s1_beat.inner_dst_port == target_port);
    tcp_mode  = (scan_mode inside {[MODE_SYN:MODE_ACK]});

    verdict           = V_NONE;
    resend            = 1'b0;
    res_valid         = 1'b0;
    retries_left_next = retries_left;
    decided_next      = decided;

    if (s1_beat.opcode == OP_START) begin
      retries_left_next = retry_limit;
      decided_next      = 1'b0;
    end else if (!decided) begin
      case (s1_beat.opcode)
        OP_TCP: begin
          if (tcp_mode && from_host && fwd_ports) begin
            if (scan_mode == MODE_SYN) begin
              if (s1_beat.rst_bit) begin
                verdict = V_CLOSED;
              end else if (s1_beat.syn_bit || s1_beat.ack_bit) begin
                verdict = V_OPEN;
              end
            end else if (s1_beat.rst_bit) begin
              verdict = (scan_mode == MODE_ACK) ? V_UNFILT : V_CLOSED;
            end
          end
        end
        OP_ICMP: begin
          if (s1_beat.icmp_type == ICMP_UNREACH && from_host && quoted) begin
            if (tcp_mode) begin
              if (filter_code(s1_beat.icmp_code, 1'b1)) begin
                verdict = V_FILTERED;
              end
            end else if (scan_mode == MODE_UDP) begin
              if (s1_beat.icmp_code == CODE_PORT) begin
                verdict = V_CLOSED;
              end else if (filter_code(s1_beat.icmp_code, 1'b0)) begin
                verdict = V_FILTERED;
              end
            end
          end
        end
        OP_UDP: begin
          if (scan_mode == MODE_UDP && from_host && fwd_ports) begin
            verdict = V_OPEN;
          end
        end
        OP_TIMEOUT: begin
          if (retries_left != 4'd0) begin
            retries_left_next = retries_left - 4'd1;
            resend            = 1'b1;
          end else if (scan_mode inside {MODE_NULL, MODE_FIN, MODE_XMAS, MODE_UDP}) begin
            verdict = V_OPENFILT;
          end else begin
            verdict = V_FILTERED;
          end
        end
        default: ;
      endcase
      if (verdict != V_NONE) begin
        decided_next = 1'b1;
      end
      res_valid = resend || (verdict != V_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retries_left <= RETRY_LIMIT_RESET;
      decided      <= 1'b0;
      out_valid    <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && res_valid;
      if (s1_valid) begin
        retries_left <= retries_left_next;
        decided      <= decided_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv && s1_valid && res_valid) begin
      out_beat.verdict <= verdict;
      out_beat.resend  <= resend;
    end
  end

endmodule

@@ src/ppr_checker.sv @@
// port-level checks on the classifier result channel, bound to the classifier core
// depends on ppr_pkg and port_probe_reply_classifier_core_defines.svh
`include "port_probe_reply_classifier_core_defines.svh"

module ppr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_verdict,
  input logic       out_resend
);
  import ppr_pkg::*;

  // a stalled result beat holds
  `PPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_verdict) && $stable(out_resend))
  // a resend beat never carries a verdict
  `PPR_ASSERT_SAME(a_resend_none, out_valid && out_resend, out_verdict == V_NONE)
  // a beat with no verdict is always a resend
  `PPR_ASSERT_SAME(a_none_resend, out_valid && out_verdict == V_NONE, out_resend)
  // nothing comes out right after reset
  `PPR_ASSERT_SAME(a_reset_quiet, $past(rst), !out_valid)

endmodule

bind port_probe_reply_classifier_core ppr_checker u_ppr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_verdict (out_ch.data.verdict),
  .out_resend  (out_ch.data.resend)
);

@@ dv/ppr_checker.sv @@
`timescale 1ns / 100ps
// result checker for the port probe reply classifier: mirrors the config writes,
// predicts the result beat, if any, of each accepted input beat and compares it with the output
// depends on ppr_pkg and ppr_if
module ppr_scoreboard
  import ppr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  ppr_in_if                      in_ch,
  ppr_out_if                     out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int unsigned            fails,
  output int unsigned            waiting
);

  logic [2:0]  mode_r;
  logic [31:0] host_r;
  logic [15:0] tport_r;
  logic [15:0] lport_r;
  logic [3:0]  retry_lim_r;
  logic [3:0]  retries_r;
  logic        decided_r;
  out_beat_t   verdict_q[$];

  // updates the probe state and returns 1 when the beat yields a result
  function automatic bit classify_beat(input in_beat_t b, output out_beat_t res);
    verdict_t v;
    logic     from_host;
    logic     fwd_ports;
    logic     quoted;
    logic     tcp_mode;
    logic     blocked;
    res = '0;
    v = V_NONE;
    if (b.opcode == OP_START) begin
      retries_r = retry_lim_r;
      decided_r = 1'b0;
      return 1'b0;
    end
    if (decided_r) return 1'b0;
    if (b.opcode == OP_TIMEOUT) begin
      if (retries_r != 4'd0) begin
        retries_r = retries_r - 4'd1;
        res.resend = 1'b1;
        return 1'b1;
      end
      v = (mode_r inside {MODE_NULL, MODE_FIN, MODE_XMAS, MODE_UDP}) ? V_OPENFILT : V_FILTERED;
    end else begin
      from_host = (b.src_addr == host_r);
      fwd_ports = (b.src_port == tport_r) && (b.dst_port == lport_r);
      quoted = (b.inner_src_port == lport_r) && (b.inner_dst_port == tport_r);
      tcp_mode = (mode_r <= MODE_ACK);
      blocked = b.icmp_code inside {CODE_HOST, CODE_PROTO, CODE_NET_PROHI,
                                    CODE_HOST_PROH, CODE_ADMIN};
      case (b.opcode)
        OP_TCP: begin
          if (tcp_mode && from_host && fwd_ports) begin
            if (mode_r == MODE_SYN) begin
              if (b.rst_bit) v = V_CLOSED;
              else if (b.syn_bit || b.ack_bit) v = V_OPEN;
            end else if (b.rst_bit) begin
              v = (mode_r == MODE_ACK) ? V_UNFILT : V_CLOSED;
            end
          end
        end
        OP_ICMP: begin
          if (b.icmp_type == ICMP_UNREACH && from_host && quoted) begin
            if (tcp_mode) begin
              if (blocked || b.icmp_code == CODE_PORT) v = V_FILTERED;
            end else if (mode_r == MODE_UDP) begin
              if (b.icmp_code == CODE_PORT) v = V_CLOSED;
              else if (blocked) v = V_FILTERED;
            end
          end
        end
        OP_UDP: begin
          if (mode_r == MODE_UDP && from_host && fwd_ports) v = V_OPEN;
        end
        default: ;
      endcase
    end
    if (v == V_NONE) return 1'b0;
    decided_r = 1'b1;
    res.verdict = v;
    return 1'b1;
  endfunction

  task automatic log_miss(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] ppr_scoreboard: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    out_beat_t got;
    if (rst) begin
      mode_r = MODE_SYN;
      host_r = '0;
      tport_r = '0;
      lport_r = LOCAL_PORT_RESET;
      retry_lim_r = RETRY_LIMIT_RESET;
      retries_r = RETRY_LIMIT_RESET;
      decided_r = 1'b0;
      verdict_q.delete();
      fails = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SCAN_MODE:   mode_r = cfg_data[2:0];
          REG_TARGET_ADDR: host_r = cfg_data[31:0];
          REG_TARGET_PORT: tport_r = cfg_data[15:0];
          REG_LOCAL_PORT:  lport_r = cfg_data[15:0];
          REG_RETRY_LIMIT: retry_lim_r = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (verdict_q.size() == 0) begin
          log_miss($sformatf("unexpected beat verdict %0d resend %0d", got.verdict, got.resend));
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict)
            log_miss($sformatf("verdict expected %0d got %0d", want.verdict, got.verdict));
          if (got.resend !== want.resend)
            log_miss($sformatf("resend expected %0d got %0d", want.resend, got.resend));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (classify_beat(in_ch.data, want)) verdict_q.push_back(want);
      end
    end
    waiting = verdict_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// top of the port probe reply classifier testbench: clock, reset, config writes,
// input beats and result-side stalls; ppr_scoreboard does the prediction and compare
// depends on ppr_pkg, ppr_if, ppr_scoreboard and port_probe_reply_classifier_core
module tb_top;
  import ppr_pkg::*;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_SLOW, RX_COIN} rx_style_t;

  localparam int unsigned     PHASES         = 14;
  localparam int unsigned     BEATS_PER_PASS = 90;
  localparam int unsigned     SETTLE_CYCLES  = 4;
  localparam longint unsigned RUN_LIMIT_NS   = 10_000_000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            fails;
  int unsigned            waiting;

  logic [31:0] tgt_addr;
  logic [15:0] tgt_port;
  logic [15:0] loc_port;
  int unsigned burst_left;
  rx_style_t   rx_style;
  int unsigned rx_cycle;
  logic [7:0]  unreach_codes [6] = '{CODE_HOST, CODE_PROTO, CODE_PORT, CODE_NET_PROHI,
                                     CODE_HOST_PROH, CODE_ADMIN};

  ppr_in_if  in_ch ();
  ppr_out_if out_ch ();

  port_probe_reply_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppr_scoreboard chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .waiting   (waiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rx_style <= RX_FREE;
      rx_cycle <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
      case (rx_style)
        RX_FREE:  out_ch.ready <= 1'b1;
        RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SLOW:  out_ch.ready <= (rx_cycle % 8 == 0);
        default:  out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // beat that matches the current probe in every address and port field
  function automatic in_beat_t hit(opcode_t op);
    in_beat_t b;
    b = '0;
    b.opcode = op;
    b.src_addr = tgt_addr;
    b.src_port = tgt_port;
    b.dst_port = loc_port;
    b.icmp_type = ICMP_UNREACH;
    b.inner_src_port = loc_port;
    b.inner_dst_port = tgt_port;
    return b;
  endfunction

  function automatic in_beat_t random_reply();
    in_beat_t    b;
    int unsigned k;
    k = $urandom_range(0, 2);
    b = hit(k == 0 ? OP_TCP : (k == 1 ? OP_ICMP : OP_UDP));
    b.syn_bit = 1'($urandom_range(0, 1));
    b.ack_bit = 1'($urandom_range(0, 1));
    b.rst_bit = ($urandom_range(0, 3) == 0);
    b.icmp_code = ($urandom_range(0, 3) != 0) ? unreach_codes[3'($urandom_range(0, 5))]
                                               : 8'($urandom);
    if ($urandom_range(0, 9) == 0) b.icmp_type = 8'($urandom);
    return b;
  endfunction

  function automatic in_beat_t near_miss();
    in_beat_t    b;
    logic [31:0] flip32;
    logic [15:0] flip16;
    logic [7:0]  flip8;
    b = random_reply();
    flip32 = 32'd1 << $urandom_range(0, 31);
    flip16 = 16'd1 << $urandom_range(0, 15);
    flip8 = 8'd1 << $urandom_range(0, 7);
    case ($urandom_range(0, 5))
      0: b.src_addr = b.src_addr ^ flip32;
      1: b.src_port = b.src_port ^ flip16;
      2: b.dst_port = b.dst_port ^ flip16;
      3: b.inner_src_port = b.inner_src_port ^ flip16;
      4: b.inner_dst_port = b.inner_dst_port ^ flip16;
      default: b.icmp_type = b.icmp_type ^ flip8;
    endcase
    return b;
  endfunction

  function automatic in_beat_t noise();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  task automatic send(in_beat_t b);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off until every expected result beat is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic setup(logic [31:0] mode, logic [31:0] addr, logic [15:0] tport,
                       logic [15:0] lport, logic [3:0] retries);
    drain();
    tgt_addr = addr;
    tgt_port = tport;
    loc_port = lport;
    cfg_write(REG_SCAN_MODE, mode);
    cfg_write(REG_TARGET_ADDR, addr);
    cfg_write(REG_TARGET_PORT, {16'd0, tport});
    cfg_write(REG_LOCAL_PORT, {16'd0, lport});
    cfg_write(REG_RETRY_LIMIT, {28'd0, retries});
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    in_beat_t    b;
    int unsigned n;
    int unsigned steps;
    int unsigned pick;
    logic [31:0] mode;
    logic [31:0] addr;
    logic [15:0] tport;
    logic [15:0] lport;
    logic [3:0]  retries;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SCAN_MODE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    tgt_addr = '0;
    tgt_port = '0;
    loc_port = LOCAL_PORT_RESET;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed beats on the reset config: syn scan, three retries
    b = hit(OP_TCP);
    b.syn_bit = 1'b1;
    b.ack_bit = 1'b1;
    send(b);
    send(b);
    send(hit(OP_START));
    b = hit(OP_TCP);
    b.rst_bit = 1'b1;
    send(b);
    send(hit(OP_START));
    send(hit(OP_TCP));
    b = hit(OP_ICMP);
    b.icmp_code = CODE_ADMIN;
    send(b);
    send(hit(OP_START));
    repeat (4) send(hit(OP_TIMEOUT));
    send(hit(OP_START));
    for (int k = 1; k <= 3; k++) begin
      b = hit(OP_TCP);
      b.rst_bit = 1'b1;
      b.opcode = 3'(OP_START) + 3'(k);
      send(b);
    end
    b = hit(OP_ICMP);
    b.icmp_type = ICMP_UNREACH + 8'd1;
    b.icmp_code = CODE_HOST;
    send(b);
    b = hit(OP_ICMP);
    b.src_addr = '1;
    b.icmp_code = CODE_HOST;
    send(b);
    send(in_beat_t'('1));
    b = hit(OP_ICMP);
    b.icmp_code = CODE_PORT;
    send(b);

    for (int p = 0; p < PHASES; p++) begin
      mode = (p == 12) ? '1 : 32'(p % 6);
      addr = (p == 2) ? '1 : (p == 3) ? '0 : $urandom;
      tport = (p == 2) ? '1 : (p == 3) ? '0 : 16'($urandom);
      lport = (p == 2) ? '0 : (p == 3) ? '1 : (p == 4) ? tport : 16'($urandom);
      retries = (p == 0) ? 4'd0 : (p == 1 || p == 13) ? '1 : 4'($urandom_range(0, 6));
      setup(mode, addr, tport, lport, retries);
      n = 0;
      while (n < BEATS_PER_PASS) begin
        if ($urandom_range(0, 15) == 0) drain();
        send(hit(OP_START));
        n++;
        steps = $urandom_range(1, 24);
        repeat (steps) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            send(hit(OP_TIMEOUT));
          end else if (pick < 70) begin
            send(random_reply());
          end else if (pick < 92) begin
            send(near_miss());
          end else begin
            send(noise());
          end
          n++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
